>>> hw/rtl/mmu_bank_mapper_bus_decode_macros.svh
// Assertion macros for the bank mapper checker.
// Used by mbm_checker.sv only; no other dependencies.
`ifndef MMU_BANK_MAPPER_BUS_DECODE_MACROS_SVH
`define MMU_BANK_MAPPER_BUS_DECODE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmu bank mapper check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmu bank mapper check failed");

`endif

>>> hw/rtl/mbm_pkg.sv
// Shared constants and types for the MMU bank mapper and bus decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mbm_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned RamAddrW  = 21;
  localparam int unsigned RegIdxW   = 4;

  // Register addresses on the CPU bus.
  localparam logic [11:0] BankRegPage = 12'hFFA;   // 0xFFA0..0xFFAF
  localparam logic [15:0] Init0Addr   = 16'hFF90;
  localparam logic [15:0] Init1Addr   = 16'hFF91;

  localparam logic [7:0]  PageFF      = 8'hFF;
  localparam logic [7:0]  PageFE      = 8'hFE;
  localparam logic [10:0] VecBlock    = 11'h7FF;   // addr[15:5] of 0xFFE0..0xFFFF
  localparam logic [3:0]  TopOffset   = 4'hF;      // addr[12:9] of offsets 0x1E00..0x1FFF

  localparam logic [7:0]  PinnedBank  = 8'h3F;
  localparam logic [7:0]  BankFlip    = 8'h38;
  localparam logic [2:0]  BankSeven   = 3'h7;
  localparam logic [15:0] SamIdleAddr = 16'hFFFF;

  localparam logic [7:0]  Init0Reset  = 8'h80;
  localparam logic [7:0]  Init1Reset  = 8'h00;

  // Init byte 0 bit positions.
  localparam int unsigned Init0MapEn  = 6;
  localparam int unsigned Init0FeFix  = 3;
  localparam int unsigned Init0IoVec  = 7;

  // Register write request from the decoder to the register file.
  typedef struct packed {
    logic                bank_we;
    logic                init0_we;
    logic                init1_we;
    logic [RegIdxW-1:0]  idx;
    logic [DataW-1:0]    data;
  } mbm_wr_t;

  // One decoded bus cycle.
  typedef struct packed {
    logic                claimed;
    logic                reg_read_valid;
    logic [DataW-1:0]    read_data;
    logic                ram_enable;
    logic                ram_write;
    logic [RamAddrW-1:0] ram_addr;
    logic [DataW-1:0]    ram_wdata;
    logic                sam_read;
    logic [AddrW-1:0]    sam_addr;
  } mbm_res_t;

endpackage

>>> hw/rtl/mbm_regs.sv
// Bank register file (two tasks of eight) and the two init bytes.
// Depends on mbm_pkg for widths, reset values and the write request type.
`timescale 1ns / 1ps

module mbm_regs
  import mbm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  mbm_wr_t            wr,
  input  logic [RegIdxW-1:0] rd_idx,
  output logic [DataW-1:0]   rd_data,
  output logic [DataW-1:0]   init0,
  output logic [DataW-1:0]   init1
);

  localparam int unsigned Depth = 1 << RegIdxW;

  logic [DataW-1:0] bank_r [Depth];
  logic [DataW-1:0] init0_r;
  logic [DataW-1:0] init1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Depth; i++) begin
        bank_r[i] <= '0;
      end
      init0_r <= Init0Reset;
      init1_r <= Init1Reset;
    end else begin
      if (wr.bank_we) begin
        bank_r[wr.idx] <= wr.data;
      end
      if (wr.init0_we) begin
        init0_r <= wr.data;
      end
      if (wr.init1_we) begin
        init1_r <= wr.data;
      end
    end
  end

  assign rd_data = bank_r[rd_idx];
  assign init0   = init0_r;
  assign init1   = init1_r;

endmodule

>>> hw/rtl/mbm_decode.sv
// Combinational bus decoder: register access, bank translation, RAM or board select.
// Depends on mbm_pkg for constants and the request and result types.
`timescale 1ns / 1ps

module mbm_decode
  import mbm_pkg::*;
(
  input  logic               en,
  input  logic               func,
  input  logic [AddrW-1:0]   addr,
  input  logic [DataW-1:0]   wdata,
  input  logic [DataW-1:0]   bank_data,
  input  logic [DataW-1:0]   init0,
  input  logic [DataW-1:0]   init1,
  output logic [RegIdxW-1:0] rd_idx,
  output mbm_wr_t            wr,
  output mbm_res_t           res
);

  logic             hit_bank;
  logic             hit_init0;
  logic             hit_init1;
  logic             hit_reg;
  logic             ffxx;
  logic             altvec;
  logic             io;
  logic             feflag;
  logic [DataW-1:0] bank;
  logic [DataW-1:0] bank_x;
  logic             mboard;
  logic             inner;
  logic             ram_hit;

  assign hit_bank  = (addr[15:4] == BankRegPage);
  assign hit_init0 = (addr == Init0Addr);
  assign hit_init1 = (addr == Init1Addr);
  assign hit_reg   = hit_bank || hit_init0 || hit_init1;

  // A register read shares the single read port with the map lookup.
  assign rd_idx = hit_bank ? addr[3:0] : {init1[0], addr[15:13]};

  assign ffxx   = (addr[15:8] == PageFF);
  assign altvec = (addr[15:5] == VecBlock) && !init0[Init0IoVec];
  assign io     = ffxx && !altvec;
  assign feflag = (addr[15:8] == PageFE) && init0[Init0FeFix];

  assign bank   = (ffxx || feflag) ? PinnedBank : bank_data;
  assign bank_x = bank ^ BankFlip;
  assign mboard = (bank_x[7:3] == 5'd0);
  // Bank seven stays on the board except for the top 512 bytes of a non-I/O page.
  assign inner  = !mboard ||
                  ((bank_x[2:0] == BankSeven) && (addr[12:9] == TopOffset) && !io);
  assign ram_hit = !hit_reg && init0[Init0MapEn] && inner;

  always_comb begin
    wr.bank_we  = en && !func && hit_bank;
    wr.init0_we = en && !func && hit_init0;
    wr.init1_we = en && !func && hit_init1;
    wr.idx      = addr[3:0];
    wr.data     = wdata;
  end

  always_comb begin
    res.claimed        = hit_reg || ram_hit;
    res.reg_read_valid = hit_reg && func;
    res.read_data      = '0;
    if (hit_reg && func) begin
      if (hit_bank) begin
        res.read_data = bank_data;
      end else if (hit_init0) begin
        res.read_data = init0;
      end else begin
        res.read_data = init1;
      end
    end
    res.ram_enable = ram_hit;
    res.ram_write  = ram_hit && !func;
    res.ram_addr   = ram_hit ? {bank_x, addr[12:0]} : '0;
    res.ram_wdata  = (ram_hit && !func) ? wdata : '0;
    res.sam_read   = res.claimed || func;
    res.sam_addr   = res.claimed ? SamIdleAddr : addr;
  end

endmodule

>>> hw/rtl/mmu_bank_mapper_bus_decode.sv
// Top level of the MMU bank mapper and bus decoder.
// Depends on mbm_pkg, mbm_regs and mbm_decode.
`timescale 1ns / 1ps

// One transfer on the input stream is one CPU bus cycle; it yields exactly one
// result transfer, in order. The block accepts a transfer every clock cycle
// while the output is not stalled. Each cycle is first captured in an input
// register, then decoded in a single pass against the bank registers and the
// init bytes, and the result is held in an output register. Register writes
// take effect when the cycle leaves the input register, so the next cycle
// always sees them. While a result waits on out_tready, the input register can
// still take one transfer; in_tready then stays low until the result drains.
// in_tready also stays low while reset is asserted. After reset all bank
// registers read zero, init byte 0 reads 0x80 (mapping off) and init byte 1
// reads zero.

module mmu_bank_mapper_bus_decode
  import mbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one CPU bus cycle per transfer.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] addr, [23:16] wdata
  input  logic        in_tuser,   // [0] func (1 = read, 0 = write)
  // Result channel: one decoded cycle per transfer.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [0] claimed, [8:1] read_data, [9] ram_enable,
                                  // [10] ram_write, [31:11] ram_addr, [39:32] ram_wdata,
                                  // [40] sam_read, [56:41] sam_addr, [63:57] zero
  output logic        out_tuser   // [0] reg_read_valid
);

  // Input register.
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               s1_func_r;
  logic [AddrW-1:0]   s1_addr_r;
  logic [DataW-1:0]   s1_wdata_r;

  // Result register.
  logic               out_valid_r;
  logic               out_valid_nxt;
  mbm_res_t           out_res_r;

  logic               in_fire;
  logic               out_free;
  logic               s1_adv;

  logic [RegIdxW-1:0] rd_idx;
  logic [DataW-1:0]   bank_data;
  logic [DataW-1:0]   init0;
  logic [DataW-1:0]   init1;
  mbm_wr_t            wr;
  mbm_res_t           res;

  // The result register frees up when it is empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = rst_n && (!s1_valid_r || out_free);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r  <= in_tuser;
      s1_addr_r  <= in_tdata[15:0];
      s1_wdata_r <= in_tdata[23:16];
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  // Writes are committed only when the cycle moves into the result register.
  mbm_decode u_decode (
    .en        (s1_adv),
    .func      (s1_func_r),
    .addr      (s1_addr_r),
    .wdata     (s1_wdata_r),
    .bank_data (bank_data),
    .init0     (init0),
    .init1     (init1),
    .rd_idx    (rd_idx),
    .wr        (wr),
    .res       (res)
  );

  mbm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_idx  (rd_idx),
    .rd_data (bank_data),
    .init0   (init0),
    .init1   (init1)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.reg_read_valid;
  assign out_tdata  = {7'd0,
                       out_res_r.sam_addr,
                       out_res_r.sam_read,
                       out_res_r.ram_wdata,
                       out_res_r.ram_addr,
                       out_res_r.ram_write,
                       out_res_r.ram_enable,
                       out_res_r.read_data,
                       out_res_r.claimed};

endmodule

>>> hw/rtl/mbm_checker.sv
// Port-level checker for the MMU bank mapper and its bind to the top level.
// Depends on mmu_bank_mapper_bus_decode_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`include "mmu_bank_mapper_bus_decode_macros.svh"

module mbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  logic        stall;
  logic [64:0] out_word;
  logic        unclaimed_v;
  logic        quiet_regs;
  logic        claimed_v;
  logic        sam_idle;
  logic        no_ram_v;
  logic        ram_zero;

  assign stall       = out_tvalid && !out_tready;
  assign out_word    = {out_tuser, out_tdata};
  assign unclaimed_v = out_tvalid && !out_tdata[0];
  assign quiet_regs  = !out_tdata[9] && !out_tuser && (out_tdata[8:1] == 8'd0);
  assign claimed_v   = out_tvalid && out_tdata[0];
  assign sam_idle    = out_tdata[40] && (out_tdata[56:41] == 16'hFFFF);
  assign no_ram_v    = out_tvalid && !out_tdata[9];
  assign ram_zero    = !out_tdata[10] && (out_tdata[31:11] == 21'd0) &&
                       (out_tdata[39:32] == 8'd0);

  // A stalled result holds.
  `MBM_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_tvalid && $stable(out_word))

  // A cycle the block does not claim touches neither registers nor RAM.
  `MBM_ASSERT_IMPL(a_unclaimed_idle, clk, rst_n, unclaimed_v, quiet_regs)

  // A claimed cycle is shown to the board as a read of the top address.
  `MBM_ASSERT_IMPL(a_claimed_sam, clk, rst_n, claimed_v, sam_idle)

  // RAM fields stay zero without a RAM access.
  `MBM_ASSERT_IMPL(a_ram_fields, clk, rst_n, no_ram_v, ram_zero)

endmodule

bind mmu_bank_mapper_bus_decode mbm_checker u_mbm_checker (.*);
